### hw/rtl/beam_element_stiffness_core_macros.svh
// ----------------------------------------------------------------------------
// Beam element stiffness assertion macros
// Shared concurrent assertion forms for the stiffness core.
// ----------------------------------------------------------------------------
`ifndef BEAM_ELEMENT_STIFFNESS_CORE_MACROS_SVH
`define BEAM_ELEMENT_STIFFNESS_CORE_MACROS_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define BES_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Asserts that an antecedent implies a consequent in the next cycle.
`define BES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/bes_pkg.sv
// ----------------------------------------------------------------------------
// Beam element stiffness package
// Shared constants and types for the frame element stiffness core.
// ----------------------------------------------------------------------------
package bes_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam logic [63:0] CAP63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE30 = 64'h0000_0000_4000_0000;
    localparam int ENTRY_COUNT = 36;

    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_AREA    = 2'd1;
    localparam logic [1:0] REG_MOMENT  = 2'd2;

    typedef struct packed {
        logic        zero;
        logic        dxneg;
        logic        dyneg;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] d;
        logic [63:0] e;
        logic [63:0] f;
        logic        sa;
        logic        sb;
        logic        sd;
        logic        se;
        logic        sf;
        logic [63:0] cm;
        logic [63:0] sm;
    } scal_t;

    // The 64-bit operand is split into halves so that each product is 32 by 32 bits.
    function automatic logic [63:0] msh30(input logic [63:0] x, input logic [31:0] c);
        logic [63:0] ph;
        logic [63:0] pl;
        ph = {32'd0, x[63:32]} * {32'd0, c};
        pl = {32'd0, x[31:0]} * {32'd0, c};
        return {ph[61:0], 2'b00} + {30'd0, pl[63:30]};
    endfunction

endpackage

### hw/rtl/bes_div.sv
// ----------------------------------------------------------------------------
// Beam element stiffness divider
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module bes_div
    import bes_pkg::*;
#(
    parameter int NW = 128,
    parameter int SW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [63:0]   den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic [NW-1:0] n_reg [NW+1];
    logic [NW-1:0] q_reg [NW+1];
    logic [64:0]   r_reg [NW+1];
    logic [63:0]   d_reg [NW+1];
    logic [SW-1:0] s_reg [NW+1];
    logic [NW:0]   v_reg;

    always_comb
    begin
        n_reg[0] = num;
        q_reg[0] = '0;
        r_reg[0] = '0;
        d_reg[0] = den;
        s_reg[0] = side_in;
        v_reg[0] = in_valid;
    end

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [65:0] sh;
        logic        ge;
        assign sh = {r_reg[i], n_reg[i][NW-1-i]};
        assign ge = sh >= {2'b00, d_reg[i]};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg[i+1] <= 1'b0;
            end else if (adv) begin
                v_reg[i+1] <= v_reg[i];
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv) begin
                n_reg[i+1] <= n_reg[i];
                d_reg[i+1] <= d_reg[i];
                s_reg[i+1] <= s_reg[i];
                r_reg[i+1] <= ge ? 65'(sh - {2'b00, d_reg[i]}) : sh[64:0];
                q_reg[i+1] <= q_reg[i] | (NW'(ge) << (NW-1-i));
            end
        end
    end

    assign out_valid = v_reg[NW];
    assign quo = q_reg[NW];
    assign side_out = s_reg[NW];

endmodule

### hw/rtl/bes_sqrt.sv
// ----------------------------------------------------------------------------
// Beam element stiffness square root
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module bes_sqrt
    import bes_pkg::*;
#(
    parameter int SW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [127:0]  rad,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [63:0]   root,
    output logic [SW-1:0] side_out
);

    localparam int NB = 57;

    logic [127:0]  n_reg [NB+1];
    logic [63:0]   r_reg [NB+1];
    logic [60:0]   m_reg [NB+1];
    logic [SW-1:0] s_reg [NB+1];
    logic [NB:0]   v_reg;

    always_comb
    begin
        n_reg[0] = rad;
        r_reg[0] = '0;
        m_reg[0] = '0;
        s_reg[0] = side_in;
        v_reg[0] = in_valid;
    end

    for (genvar i = 0; i < NB; i++) begin : g_stage
        logic [60:0] rem2;
        logic [60:0] trial;
        logic        ge;
        assign rem2 = {m_reg[i][58:0], n_reg[i][2*(NB-1-i)+1 -: 2]};
        assign trial = {r_reg[i][58:0], 2'b01};
        assign ge = rem2 >= trial;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg[i+1] <= 1'b0;
            end else if (adv) begin
                v_reg[i+1] <= v_reg[i];
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv) begin
                n_reg[i+1] <= n_reg[i];
                s_reg[i+1] <= s_reg[i];
                m_reg[i+1] <= ge ? (rem2 - trial) : rem2;
                r_reg[i+1] <= {r_reg[i][62:0], ge};
            end
        end
    end

    assign out_valid = v_reg[NB];
    assign root = r_reg[NB];
    assign side_out = s_reg[NB];

endmodule

### hw/rtl/bes_scalars.sv
// ----------------------------------------------------------------------------
// Beam element stiffness scalars
// Length, direction cosines and the stiffness scalars through a divider chain.
// ----------------------------------------------------------------------------
module bes_scalars
    import bes_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic [31:0]        modulus,
    input  logic [31:0]        area,
    input  logic [31:0]        moment,
    output logic               out_valid,
    output scal_t              out_s
);

    localparam int SH0 = 2 * (32 - FRAC_BITS);
    localparam int SHT = 62 - FRAC_BITS;
    localparam int SHA = 64 - 2 * FRAC_BITS;
    localparam int SHF = 65 - 2 * FRAC_BITS;

    typedef struct packed {
        logic        zero;
        logic        dxneg;
        logic        dyneg;
        logic [32:0] ux;
        logic [32:0] uy;
        logic [63:0] ea;
        logic [63:0] ei;
    } pre_t;

    pre_t          p0_reg;
    logic          v0_reg;
    logic [127:0]  rad_reg;
    logic signed [32:0] dx, dy;
    pre_t          p_next;

    always_comb
    begin
        dx = 33'(end_x) - 33'(start_x);
        dy = 33'(end_y) - 33'(start_y);
        p_next.dxneg = dx[32];
        p_next.dyneg = dy[32];
        p_next.ux = dx[32] ? 33'(-dx) : dx;
        p_next.uy = dy[32] ? 33'(-dy) : dy;
        p_next.zero = (dx == '0) && (dy == '0);
        p_next.ea = {32'd0, modulus} * {32'd0, area};
        p_next.ei = {32'd0, modulus} * {32'd0, moment};
    end

    logic [65:0] sqx_reg, sqy_reg;
    pre_t        p1_reg;
    logic        v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            p0_reg  <= p_next;
            sqx_reg <= {33'd0, p0_reg.ux} * {33'd0, p0_reg.ux};
            sqy_reg <= {33'd0, p0_reg.uy} * {33'd0, p0_reg.uy};
            p1_reg  <= p0_reg;
            rad_reg <= (128'(sqx_reg) + 128'(sqy_reg)) << SH0;
        end
    end

    logic  v2_reg;
    pre_t  p2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv) begin
            p2_reg <= p1_reg;
        end
    end

    logic        vq;
    logic [63:0] lq;
    pre_t        pq;

    bes_sqrt #(.SW($bits(pre_t))) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (v2_reg),
        .rad      (rad_reg),
        .side_in  (p2_reg),
        .out_valid(vq),
        .root     (lq),
        .side_out (pq)
    );

    logic [63:0] lqd;
    assign lqd = pq.zero ? 64'd1 : lq;

    // Four parallel divisions: cosine, sine, axial and bending base f.
    typedef struct packed {
        pre_t        p;
        logic [63:0] l;
    } s1_t;
    s1_t s1_in, s1_c, s1_s, s1_a, s1_f;
    logic vc, vs, va, vf;
    logic [127:0] qc, qs, qa, qf;
    assign s1_in = '{p: pq, l: lqd};

    bes_div #(.NW(128), .SW($bits(s1_t))) u_div_c (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(vq),
        .num(128'(pq.ux) << SHT), .den(lqd), .side_in(s1_in),
        .out_valid(vc), .quo(qc), .side_out(s1_c));
    bes_div #(.NW(128), .SW(1)) u_div_s (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(vq),
        .num(128'(pq.uy) << SHT), .den(lqd), .side_in(1'b0),
        .out_valid(vs), .quo(qs), .side_out(s1_s[0]));
    bes_div #(.NW(128), .SW(1)) u_div_a (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(vq),
        .num(128'(pq.ea) << SHA), .den(lqd), .side_in(1'b0),
        .out_valid(va), .quo(qa), .side_out(s1_a[0]));
    bes_div #(.NW(128), .SW(1)) u_div_f (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(vq),
        .num(128'(pq.ei) << SHF), .den(lqd), .side_in(1'b0),
        .out_valid(vf), .quo(qf), .side_out(s1_f[0]));

    assign s1_s[$bits(s1_t)-1:1] = '0;
    assign s1_a[$bits(s1_t)-1:1] = '0;
    assign s1_f[$bits(s1_t)-1:1] = '0;

    typedef struct packed {
        pre_t        p;
        logic [63:0] l;
        logic [127:0] f128;
        logic [63:0] cm;
        logic [63:0] sm;
        logic [63:0] a;
        logic        sa;
    } s2_t;

    s2_t s2_in, s2_d;
    logic dsmall;
    assign s2_in.p = s1_c.p;
    assign s2_in.l = s1_c.l;
    assign s2_in.f128 = qf;
    assign s2_in.cm = (qc > 128'(ONE30)) ? ONE30 : qc[63:0];
    assign s2_in.sm = (qs > 128'(ONE30)) ? ONE30 : qs[63:0];
    assign s2_in.sa = qa > 128'(CAP63);
    assign s2_in.a = s2_in.sa ? CAP63 : qa[63:0];
    assign dsmall = qf[127:94] == '0;

    logic [127:0] qd;
    logic vd;
    logic [127:0] f3;
    assign f3 = (qf << 1) + qf;

    bes_div #(.NW(128), .SW($bits(s2_t))) u_div_d (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(vc),
        .num(f3 << 32), .den(s1_c.l), .side_in(s2_in),
        .out_valid(vd), .quo(qd), .side_out(s2_d));

    logic [127:0] qb;
    logic vb;
    s2_t s3_d;
    logic [127:0] s3_dq;
    typedef struct packed {
        s2_t          s;
        logic [127:0] dq;
    } s3_t;
    s3_t s3_in, s3_out;
    assign s3_in = '{s: s2_d, dq: qd};

    bes_div #(.NW(128), .SW($bits(s3_t))) u_div_b (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(vd),
        .num(qd << 33), .den(s2_d.l), .side_in(s3_in),
        .out_valid(vb), .quo(qb), .side_out(s3_out));

    assign s3_d = s3_out.s;
    assign s3_dq = s3_out.dq;

    logic fbig, dbig;
    logic [128:0] e129;
    always_comb
    begin
        fbig = s3_d.f128[127:94] != '0;
        dbig = s3_dq[127:94] != '0;
        e129 = {s3_d.f128, 1'b0};
        out_s.zero = s3_d.p.zero;
        out_s.dxneg = s3_d.p.dxneg;
        out_s.dyneg = s3_d.p.dyneg;
        out_s.cm = s3_d.cm;
        out_s.sm = s3_d.sm;
        out_s.sa = s3_d.sa;
        out_s.a = s3_d.a;
        out_s.sf = s3_d.f128 > 128'(CAP63);
        out_s.f = out_s.sf ? CAP63 : s3_d.f128[63:0];
        out_s.se = e129 > 129'(CAP63);
        out_s.e = out_s.se ? CAP63 : e129[63:0];
        if (fbig) begin
            out_s.sd = 1'b1;
            out_s.sb = 1'b1;
        end else begin
            out_s.sd = s3_dq > 128'(CAP63);
            out_s.sb = dbig || (qb > 128'(CAP63));
        end
        out_s.d = out_s.sd ? CAP63 : s3_dq[63:0];
        out_s.b = out_s.sb ? CAP63 : qb[63:0];
        if (out_s.zero) begin
            out_s.sa = 1'b0;
            out_s.sb = 1'b0;
            out_s.sd = 1'b0;
            out_s.se = 1'b0;
            out_s.sf = 1'b0;
            out_s.a = '0;
            out_s.b = '0;
            out_s.d = '0;
            out_s.e = '0;
            out_s.f = '0;
        end
    end

    assign out_valid = vb;
    logic unused_ok;
    assign unused_ok = ^{vs, va, vf, dsmall, s1_s[0], s1_a[0], s1_f[0]};

endmodule

### hw/rtl/bes_entries.sv
// ----------------------------------------------------------------------------
// Beam element stiffness entry stage
// Rotates the scalars into global terms and streams the 36 entries.
// ----------------------------------------------------------------------------
module bes_entries
    import bes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_valid,
    input  scal_t       s_in,
    output logic        s_take,
    output logic        valid,
    input  logic        stall,
    output logic [2:0]  row_index,
    output logic [2:0]  col_index,
    output logic signed [63:0] entry_value,
    output logic        zero_length,
    output logic        overflow,
    output logic        last_entry
);

    typedef struct packed {
        logic        neg;
        logic [64:0] mag;
        logic        sat;
    } ent_t;

    localparam logic [2:0] LAST_IDX = 3'd5;

    // Stage A: first products.
    scal_t       a_reg;
    logic        va_reg;
    logic [63:0] ac_reg, as_reg, bc_reg, bs_reg, dsm_reg, dcm_reg;
    // Stage P: second products.
    scal_t       p_reg;
    logic        vp_reg;
    logic [63:0] acc_reg, bss_reg, ass_reg, bcc_reg, acs_reg, bcs_reg, pdsm_reg, pdcm_reg;
    // Stage B: the term table.
    logic        vb_reg;
    scal_t       b_reg;
    ent_t        t00_reg, t11_reg, t01_reg, g0_reg, g1_reg, r0_reg, r1_reg;
    logic [2:0]  row_reg, col_reg;
    logic        at_last;
    logic        hold_ok;
    logic        take_p;
    logic        adv_o;
    logic        csneg, tsat;

    assign adv_o = !valid || !stall;
    assign at_last = (row_reg == LAST_IDX) && (col_reg == LAST_IDX);
    assign hold_ok = !vb_reg || (at_last && adv_o);
    assign take_p = !vp_reg || hold_ok;
    assign s_take = !va_reg || take_p;
    assign csneg = p_reg.dxneg != p_reg.dyneg;
    assign tsat = p_reg.sa || p_reg.sb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            va_reg <= 1'b0;
            vp_reg <= 1'b0;
            vb_reg <= 1'b0;
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            if (s_take) begin
                va_reg <= s_valid;
            end
            if (take_p) begin
                vp_reg <= va_reg;
            end
            if (hold_ok) begin
                vb_reg <= vp_reg;
                row_reg <= '0;
                col_reg <= '0;
            end else if (adv_o) begin
                if (col_reg == LAST_IDX) begin
                    col_reg <= '0;
                    row_reg <= row_reg + 3'd1;
                end else begin
                    col_reg <= col_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take) begin
            a_reg <= s_in;
            ac_reg <= msh30(s_in.a, s_in.cm[31:0]);
            as_reg <= msh30(s_in.a, s_in.sm[31:0]);
            bc_reg <= msh30(s_in.b, s_in.cm[31:0]);
            bs_reg <= msh30(s_in.b, s_in.sm[31:0]);
            dsm_reg <= msh30(s_in.d, s_in.sm[31:0]);
            dcm_reg <= msh30(s_in.d, s_in.cm[31:0]);
        end
        if (take_p) begin
            p_reg <= a_reg;
            acc_reg <= msh30(ac_reg, a_reg.cm[31:0]);
            bss_reg <= msh30(bs_reg, a_reg.sm[31:0]);
            ass_reg <= msh30(as_reg, a_reg.sm[31:0]);
            bcc_reg <= msh30(bc_reg, a_reg.cm[31:0]);
            acs_reg <= msh30(ac_reg, a_reg.sm[31:0]);
            bcs_reg <= msh30(bc_reg, a_reg.sm[31:0]);
            pdsm_reg <= dsm_reg;
            pdcm_reg <= dcm_reg;
        end
        if (hold_ok) begin
            b_reg <= p_reg;
            t00_reg <= '{neg: 1'b0, mag: 65'(acc_reg) + 65'(bss_reg), sat: tsat};
            t11_reg <= '{neg: 1'b0, mag: 65'(ass_reg) + 65'(bcc_reg), sat: tsat};
            if (acs_reg >= bcs_reg) begin
                t01_reg <= '{neg: csneg, mag: 65'(acs_reg - bcs_reg), sat: tsat};
            end else begin
                t01_reg <= '{neg: !csneg, mag: 65'(bcs_reg - acs_reg), sat: tsat};
            end
            g0_reg <= '{neg: !p_reg.dyneg, mag: 65'(pdsm_reg), sat: p_reg.sd};
            g1_reg <= '{neg: p_reg.dxneg, mag: 65'(pdcm_reg), sat: p_reg.sd};
            r0_reg <= '{neg: 1'b0, mag: 65'(p_reg.e), sat: p_reg.se};
            r1_reg <= '{neg: 1'b0, mag: 65'(p_reg.f), sat: p_reg.sf};
        end
    end

    // Entry selection and output register.
    logic [1:0] kr, kc;
    logic       nr, nc;
    ent_t       v;
    logic [63:0] val;
    logic        ovf;

    always_comb
    begin
        nr = row_reg >= 3'd3;
        nc = col_reg >= 3'd3;
        kr = nr ? 2'(row_reg - 3'd3) : row_reg[1:0];
        kc = nc ? 2'(col_reg - 3'd3) : col_reg[1:0];
        if (kr != 2'd2 && kc != 2'd2) begin
            if (kr == 2'd0 && kc == 2'd0) v = t00_reg;
            else if (kr == 2'd1 && kc == 2'd1) v = t11_reg;
            else v = t01_reg;
            v.neg = v.neg ^ (nr != nc);
        end else if (kr == 2'd2 && kc == 2'd2) begin
            v = (nr == nc) ? r0_reg : r1_reg;
        end else if (kr == 2'd2) begin
            v = kc[0] ? g1_reg : g0_reg;
            v.neg = v.neg ^ nc;
        end else begin
            v = kr[0] ? g1_reg : g0_reg;
            v.neg = v.neg ^ nr;
        end
        ovf = v.sat;
        if (b_reg.zero) begin
            val = '0;
            ovf = 1'b0;
        end else if (v.neg) begin
            if (v.mag > 65'(CAP63) + 65'd1) begin
                val = CAP63 + 64'd1;
                ovf = 1'b1;
            end else begin
                val = 64'(-v.mag);
            end
        end else begin
            if (v.mag > 65'(CAP63)) begin
                val = CAP63;
                ovf = 1'b1;
            end else begin
                val = v.mag[63:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid <= 1'b0;
        end else if (adv_o) begin
            valid <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_o) begin
            row_index <= row_reg;
            col_index <= col_reg;
            entry_value <= val;
            zero_length <= b_reg.zero;
            overflow <= ovf;
            last_entry <= at_last;
        end
    end

endmodule

### hw/rtl/beam_element_stiffness_core.sv
// Pipeline: after the input transfer, the first entry passes through three input
// stages, the 57-stage square root, three chained 128-stage dividers, the three
// entry stages A, P and B, and the output register.
// Elements overlap in the pipeline; the single output port streams each element's 36 entries in turn.
// Reset: rst_n is asynchronous, active low; modulus, area and moment reset to 65536 (1.0 at FRAC_BITS 16).
// ----------------------------------------------------------------------------
// Beam element stiffness core
// Streams the 36 global stiffness entries of a 2D frame element.
// ----------------------------------------------------------------------------
`include "beam_element_stiffness_core_macros.svh"
module beam_element_stiffness_core
    import bes_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         row_index,
    output logic [2:0]         col_index,
    output logic signed [63:0] entry_value,
    output logic               zero_length,
    output logic               overflow,
    output logic               last_entry,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [31:0] modulus_reg, area_reg, moment_reg;
    logic        adv, s_valid, s_take;
    scal_t       s;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            modulus_reg <= 32'd65536;
            area_reg <= 32'd65536;
            moment_reg <= 32'd65536;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODULUS: modulus_reg <= cfg_data;
                REG_AREA:    area_reg <= cfg_data;
                REG_MOMENT:  moment_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign adv = s_take || !s_valid;
    assign in_stall = !adv;

    bes_scalars #(.FRAC_BITS(FRAC_BITS)) u_scalars (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .modulus(modulus_reg), .area(area_reg), .moment(moment_reg),
        .out_valid(s_valid), .out_s(s));

    bes_entries u_entries (
        .clk(clk), .rst_n(rst_n), .s_valid(s_valid), .s_in(s), .s_take(s_take),
        .valid(out_valid), .stall(out_stall), .row_index(row_index),
        .col_index(col_index), .entry_value(entry_value),
        .zero_length(zero_length), .overflow(overflow), .last_entry(last_entry));

    `BES_ASSERT_IMP(a_last_pos, out_valid && last_entry, row_index == 3'd5 && col_index == 3'd5)
    `BES_ASSERT_IMP(a_zero_val, out_valid && zero_length, entry_value == 64'd0 && !overflow)
    `BES_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(entry_value))

endmodule
